[rtl/wsp_pkg.sv]
// ----------------------------------------------------------------------------
// wsp_pkg: shared types and constants of the weighted stride server picker
// Command, status and state codes, and the controller/datapath link structs.
// ----------------------------------------------------------------------------
package wsp_pkg;

    // Width of the slot index and result slot fields
    localparam int IDX_BITS   = 3;
    // Width of the signed preference field
    localparam int PREF_BITS  = 11;
    // Width of a stored weight
    localparam int WEIGHT_BITS = 7;
    // Full weight; the pass stride is MAX_WEIGHT minus the weight
    localparam int MAX_WEIGHT = 100;
    // Number of slots that the index field can address
    localparam int MAX_SLOTS  = 2 ** IDX_BITS;

    typedef enum logic [2:0] {
        CMD_SELECT  = 3'd0,
        CMD_ADD     = 3'd1,
        CMD_SETPREF = 3'd2,
        CMD_EXCLUDE = 3'd3,
        CMD_RESTORE = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_NONE    = 2'd1,
        STAT_PRESENT = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic accept;     // take the transaction on the input ports
        logic scan_step;  // compare one slot against the running best
        logic finish;     // apply the grant and post the select result
    } t_ctl_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic need_scan;  // the offered transaction is a select that may grant
        logic scan_last;  // the slot under compare is the last one
    } t_dp_status;

endpackage

[rtl/weighted_stride_server_picker.sv]
// Add, set preference, exclude, restore and a refused select post their
//   result in the cycle after the accepting edge; busy stays low.
// A live select walks the slot table one slot a cycle through one pass
//   comparator, then grants in the update state; busy is high meanwhile,
//   the result shows in the cycle busy drops, and only then is start taken.
// The result strobe lasts one cycle; results cannot be stalled.
// Reset is synchronous, active low, and clears every slot and flag at once.
// ----------------------------------------------------------------------------
// weighted_stride_server_picker: stride scheduler over a small slot table
// Grants the queued slot with the lowest pass and advances it by its stride.
// ----------------------------------------------------------------------------
module weighted_stride_server_picker #(
    parameter int SERVERS   = 8,
    parameter int PASS_BITS = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [2:0]                           i_command,
    input  logic [wsp_pkg::IDX_BITS-1:0]         i_server_index,
    input  logic signed [wsp_pkg::PREF_BITS-1:0] i_preference,
    output logic                                 o_valid,
    output logic                                 o_granted,
    output logic [wsp_pkg::IDX_BITS-1:0]         o_chosen_server,
    output logic [1:0]                           o_status
);
    import wsp_pkg::*;

    t_ctl_cmd   ctl_cmd;
    t_dp_status dp_status;

    // Sequence each transaction
    wsp_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_status (dp_status),
        .o_cmd    (ctl_cmd)
    );

    // Hold the slot table and results
    wsp_datapath #(
        .SERVERS   (SERVERS),
        .PASS_BITS (PASS_BITS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (ctl_cmd),
        .o_status_bits   (dp_status),
        .i_command       (i_command),
        .i_server_index  (i_server_index),
        .i_preference    (i_preference),
        .o_valid         (o_valid),
        .o_granted       (o_granted),
        .o_chosen_server (o_chosen_server),
        .o_status        (o_status)
    );

endmodule

[rtl/wsp_ctrl.sv]
// ----------------------------------------------------------------------------
// wsp_ctrl: sequencer of the weighted stride server picker
// Accepts transactions, walks the slot scan of a select and closes it out.
// ----------------------------------------------------------------------------
module wsp_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  wsp_pkg::t_dp_status i_status,
    output wsp_pkg::t_ctl_cmd   o_cmd
);
    import wsp_pkg::*;

    t_state r_state;
    t_state n_state;

    // Hold the state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Decode next state and datapath commands
    always_comb begin
        n_state         = r_state;
        o_cmd           = '0;
        busy            = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                busy         = 1'b0;
                o_cmd.accept = start;
                if (start && i_status.need_scan) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_status.scan_last) begin
                    n_state = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                o_cmd.finish = 1'b1;
                n_state      = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

[rtl/wsp_datapath.sv]
// ----------------------------------------------------------------------------
// wsp_datapath: slot table, scan comparator and result register
// Holds per-slot weight, pass and queue order; applies each command.
// ----------------------------------------------------------------------------
module wsp_datapath #(
    parameter int SERVERS   = 8,
    parameter int PASS_BITS = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  wsp_pkg::t_ctl_cmd                   i_cmd,
    output wsp_pkg::t_dp_status                 o_status_bits,
    input  logic [2:0]                          i_command,
    input  logic [wsp_pkg::IDX_BITS-1:0]        i_server_index,
    input  logic signed [wsp_pkg::PREF_BITS-1:0] i_preference,
    output logic                                o_valid,
    output logic                                o_granted,
    output logic [wsp_pkg::IDX_BITS-1:0]        o_chosen_server,
    output logic [1:0]                          o_status
);
    import wsp_pkg::*;

    // Slots beyond the reach of the index field can never be added
    localparam int NSLOT = (SERVERS < MAX_SLOTS) ? SERVERS : MAX_SLOTS;
    localparam int SW    = (NSLOT > 1) ? $clog2(NSLOT) : 1;
    localparam int CW    = $clog2(NSLOT + 1);
    localparam int PW    = PASS_BITS;

    logic                   r_present   [NSLOT];
    logic [WEIGHT_BITS-1:0] r_weight    [NSLOT];
    logic                   r_queued    [NSLOT];
    logic [PW-1:0]          r_pass      [NSLOT];
    logic [SW-1:0]          r_order     [NSLOT];
    logic [WEIGHT_BITS-1:0] r_init_pass [NSLOT];
    logic [SW-1:0]          r_init_order[NSLOT];
    logic [CW-1:0]          r_qcount;
    logic [CW-1:0]          r_acount;
    logic                   r_refuse;

    logic [SW-1:0]          r_scan_idx;
    logic                   r_found;
    logic [SW-1:0]          r_best_idx;
    logic [PW-1:0]          r_best_pass;
    logic [SW-1:0]          r_best_order;

    logic                   r_valid;
    logic                   r_granted;
    logic [IDX_BITS-1:0]    r_chosen;
    t_status                r_status;

    logic                   idx_ok;
    logic [SW-1:0]          slot_sel;
    logic [WEIGHT_BITS-1:0] clamped;
    logic                   take;
    logic [WEIGHT_BITS-1:0] inc;
    logic [PW-1:0]          inc_ext;
    logic [PW:0]            sum;
    logic                   ovf;
    logic [CW-1:0]          qlast;

    // Clamp a signed preference to 0..MAX_WEIGHT
    function automatic logic [WEIGHT_BITS-1:0] clamp_weight(
        input logic signed [PREF_BITS-1:0] pref
    );
        logic [WEIGHT_BITS-1:0] w;
        if (pref[PREF_BITS-1]) begin
            w = '0;
        end else if (pref > PREF_BITS'(MAX_WEIGHT)) begin
            w = WEIGHT_BITS'(MAX_WEIGHT);
        end else begin
            w = pref[WEIGHT_BITS-1:0];
        end
        return w;
    endfunction

    // Decode the offered slot and weight
    assign idx_ok   = ({1'b0, i_server_index} < (IDX_BITS + 1)'(NSLOT));
    assign slot_sel = i_server_index[SW-1:0];
    assign clamped  = clamp_weight(i_preference);

    // Compare the scanned slot against the running best
    assign take = r_queued[r_scan_idx] &&
                  (!r_found || (r_pass[r_scan_idx] < r_best_pass) ||
                   ((r_pass[r_scan_idx] == r_best_pass) &&
                    (r_order[r_scan_idx] < r_best_order)));

    // Form the stride add of the granted slot and its overflow
    assign inc     = WEIGHT_BITS'(MAX_WEIGHT) - r_weight[r_best_idx];
    assign inc_ext = PW'(inc);
    assign sum     = {1'b0, r_best_pass} + {1'b0, inc_ext};
    assign ovf     = sum[PW];
    assign qlast   = r_qcount - CW'(1);

    assign o_status_bits.need_scan = (i_command == CMD_SELECT) && !r_refuse;
    assign o_status_bits.scan_last = (r_scan_idx == SW'(NSLOT - 1));

    // Update the slot table, the scan and the result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NSLOT; i++) begin
                r_present[i]    <= 1'b0;
                r_weight[i]     <= '0;
                r_queued[i]     <= 1'b0;
                r_pass[i]       <= '0;
                r_order[i]      <= '0;
                r_init_pass[i]  <= '0;
                r_init_order[i] <= '0;
            end
            r_qcount     <= '0;
            r_acount     <= '0;
            r_refuse     <= 1'b0;
            r_scan_idx   <= '0;
            r_found      <= 1'b0;
            r_best_idx   <= '0;
            r_best_pass  <= '0;
            r_best_order <= '0;
            r_valid      <= 1'b0;
            r_granted    <= 1'b0;
            r_chosen     <= '0;
            r_status     <= STAT_OK;
        end else begin
            r_valid <= 1'b0;

            // Accept a transaction; all but a live select finish here
            if (i_cmd.accept) begin
                r_scan_idx   <= '0;
                r_found      <= 1'b0;
                r_best_idx   <= '0;
                r_best_pass  <= '0;
                r_best_order <= '0;
                r_granted    <= 1'b0;
                r_chosen     <= '0;
                r_status     <= STAT_OK;
                r_valid      <= !o_status_bits.need_scan;
                unique case (i_command)
                    CMD_SELECT: begin
                        r_status <= STAT_NONE;
                    end
                    CMD_ADD: begin
                        if (idx_ok) begin
                            if (r_present[slot_sel]) begin
                                r_status <= STAT_PRESENT;
                            end else begin
                                r_present[slot_sel]    <= 1'b1;
                                r_weight[slot_sel]     <= clamped;
                                r_init_pass[slot_sel]  <=
                                    WEIGHT_BITS'(MAX_WEIGHT) - clamped;
                                r_init_order[slot_sel] <= r_acount[SW-1:0];
                                r_acount               <= r_acount + CW'(1);
                                if (!r_queued[slot_sel]) begin
                                    r_queued[slot_sel] <= 1'b1;
                                    r_pass[slot_sel]   <=
                                        PW'(WEIGHT_BITS'(MAX_WEIGHT) - clamped);
                                    r_order[slot_sel]  <= r_qcount[SW-1:0];
                                    r_qcount           <= r_qcount + CW'(1);
                                end
                            end
                        end
                    end
                    CMD_SETPREF: begin
                        if (idx_ok && r_present[slot_sel]) begin
                            r_weight[slot_sel] <= clamped;
                        end
                    end
                    CMD_EXCLUDE: begin
                        if (idx_ok && r_queued[slot_sel]) begin
                            for (int i = 0; i < NSLOT; i++) begin
                                if (r_queued[i] && (r_order[i] > r_order[slot_sel])) begin
                                    r_order[i] <= r_order[i] - SW'(1);
                                end
                            end
                            r_queued[slot_sel] <= 1'b0;
                            r_order[slot_sel]  <= '0;
                            r_qcount           <= r_qcount - CW'(1);
                        end
                    end
                    CMD_RESTORE: begin
                        for (int i = 0; i < NSLOT; i++) begin
                            r_queued[i] <= r_present[i];
                            r_pass[i]   <= r_present[i] ? PW'(r_init_pass[i]) : '0;
                            r_order[i]  <= r_present[i] ? r_init_order[i] : '0;
                        end
                        r_qcount <= r_acount;
                    end
                    default: begin
                    end
                endcase
            end

            // Advance the scan one slot a cycle
            if (i_cmd.scan_step) begin
                if (take) begin
                    r_found      <= 1'b1;
                    r_best_idx   <= r_scan_idx;
                    r_best_pass  <= r_pass[r_scan_idx];
                    r_best_order <= r_order[r_scan_idx];
                end
                r_scan_idx <= r_scan_idx + SW'(1);
            end

            // Grant the best slot, or refuse and latch the sticky flag
            if (i_cmd.finish) begin
                r_valid <= 1'b1;
                if (r_found) begin
                    for (int i = 0; i < NSLOT; i++) begin
                        if (r_queued[i]) begin
                            if (ovf) begin
                                r_pass[i] <= r_pass[i] - r_best_pass;
                            end
                            if (r_order[i] > r_best_order) begin
                                r_order[i] <= r_order[i] - SW'(1);
                            end
                        end
                    end
                    r_pass[r_best_idx]  <= ovf ? inc_ext : sum[PW-1:0];
                    r_order[r_best_idx] <= qlast[SW-1:0];
                    r_granted           <= 1'b1;
                    r_chosen            <= IDX_BITS'(r_best_idx);
                    r_status            <= STAT_OK;
                end else begin
                    r_refuse  <= 1'b1;
                    r_granted <= 1'b0;
                    r_chosen  <= '0;
                    r_status  <= STAT_NONE;
                end
            end
        end
    end

    assign o_valid         = r_valid;
    assign o_granted       = r_granted;
    assign o_chosen_server = r_chosen;
    assign o_status        = r_status;

endmodule

[rtl/wsp_checker.sv]
// ----------------------------------------------------------------------------
// wsp_checker: port-level checks of the weighted stride server picker
// Watches handshake timing and result field consistency over time.
// ----------------------------------------------------------------------------
module wsp_checker (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 start,
    input logic                                 busy,
    input logic [2:0]                           i_command,
    input logic                                 o_valid,
    input logic                                 o_granted,
    input logic [wsp_pkg::IDX_BITS-1:0]         o_chosen_server,
    input logic [1:0]                           o_status
);
    import wsp_pkg::*;

    // A result never shows while a transaction is still in work
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while busy");

    // Non-select transactions answer in the next cycle
    a_short_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_command != CMD_SELECT)) |=> (o_valid && !busy))
        else $error("non-select transaction did not answer in one cycle");

    // A select either answers at once or keeps the block busy
    a_select_go: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_command == CMD_SELECT)) |=> (o_valid || busy))
        else $error("select transaction lost");

    // A grant carries ok status; no grant carries slot zero
    a_grant_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_granted ? (o_status == STAT_OK) : (o_chosen_server == '0)))
        else $error("inconsistent result fields");

endmodule

bind weighted_stride_server_picker wsp_checker u_wsp_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .busy            (busy),
    .i_command       (i_command),
    .o_valid         (o_valid),
    .o_granted       (o_granted),
    .o_chosen_server (o_chosen_server),
    .o_status        (o_status)
);
